// ===== src/debug_packet_receiver_responder_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef DEBUG_PACKET_RECEIVER_RESPONDER_MACROS_SVH
`define DEBUG_PACKET_RECEIVER_RESPONDER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define DPRR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define DPRR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== src/dprr_pkg.sv =====
package dprr_pkg;

  // Link characters.
  localparam logic [7:0] CH_START = 8'h24;  // '$'
  localparam logic [7:0] CH_CHECK = 8'h23;  // '#'
  localparam logic [7:0] CH_ACK   = 8'h2B;  // '+'
  localparam logic [7:0] CH_NACK  = 8'h2D;  // '-'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] BYTE_MASK = 8'hFF;

  // Event codes reported with each result.
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_ACK      = 3'd1;
  localparam logic [2:0] EV_NACK     = 3'd2;
  localparam logic [2:0] EV_JUNK     = 3'd3;
  localparam logic [2:0] EV_GOOD     = 3'd4;
  localparam logic [2:0] EV_BAD      = 3'd5;
  localparam logic [2:0] EV_OVERFLOW = 3'd6;

  // Default sizes.
  localparam int MAX_PACKET_BYTES_DEF = 128;
  localparam int CMDQ_DEPTH_DEF       = 4;

  // Number of reply bytes in the empty reply "$#00".
  localparam int REPLY_LEN = 4;
  localparam int REM_W     = $clog2(REPLY_LEN + 1);

  // One classified request handed from front to back.
  typedef struct packed {
    logic [2:0] ev;     // event code of the first result
    logic       reply;  // append the empty reply packet
  } cmd_t;

endpackage

// ===== src/dprr_front.sv =====
module dprr_front #(
  parameter int MAX_PACKET_BYTES = dprr_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             reply_empty_on_good_i,
  input  logic             acc_i,
  input  logic [7:0]       rx_byte_i,
  output logic             cmd_push_o,
  output dprr_pkg::cmd_t   cmd_o
);

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_HIGH    = 2'd2;
  localparam logic [1:0] PH_LOW     = 2'd3;

  // Payload capacity leaves room for '$', '#' and two digits.
  localparam logic [7:0] LEN_LIMIT = 8'(MAX_PACKET_BYTES - 4);

  logic [1:0] phase_q, phase_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] len_q, len_d;
  logic [3:0] hi_q, hi_d;
  logic       hibad_q, hibad_d;
  logic       reply_en_q;
  logic [4:0] hex;

  // Return {valid, nibble}.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  assign hex = hex_decode(rx_byte_i);

  always_comb begin
    phase_d    = phase_q;
    sum_d      = sum_q;
    len_d      = len_q;
    hi_d       = hi_q;
    hibad_d    = hibad_q;
    cmd_push_o = 1'b0;
    cmd_o.ev   = dprr_pkg::EV_NONE;
    cmd_o.reply = 1'b0;
    if (acc_i) begin
      unique case (phase_q)
        PH_IDLE: begin
          if (rx_byte_i == dprr_pkg::CH_START) begin
            phase_d = PH_PAYLOAD;
            sum_d   = 8'd0;
            len_d   = 8'd0;
            hi_d    = 4'd0;
            hibad_d = 1'b0;
          end else begin
            cmd_push_o = 1'b1;
            if (rx_byte_i == dprr_pkg::CH_ACK) begin
              cmd_o.ev = dprr_pkg::EV_ACK;
            end else if (rx_byte_i == dprr_pkg::CH_NACK) begin
              cmd_o.ev = dprr_pkg::EV_NACK;
            end else begin
              cmd_o.ev = dprr_pkg::EV_JUNK;
            end
          end
        end
        PH_PAYLOAD: begin
          if (rx_byte_i == dprr_pkg::CH_CHECK) begin
            phase_d = PH_HIGH;
          end else if (len_q >= LEN_LIMIT) begin
            // drop the packet
            cmd_push_o = 1'b1;
            cmd_o.ev   = dprr_pkg::EV_OVERFLOW;
            phase_d    = PH_IDLE;
            sum_d      = 8'd0;
            len_d      = 8'd0;
          end else begin
            sum_d = sum_q + rx_byte_i;
            len_d = len_q + 8'd1;
          end
        end
        PH_HIGH: begin
          hi_d    = hex[4] ? hex[3:0] : 4'd0;
          hibad_d = ~hex[4];
          phase_d = PH_LOW;
        end
        PH_LOW: begin
          cmd_push_o = 1'b1;
          if (!hex[4] || hibad_q || ({hi_q, hex[3:0]} != sum_q)) begin
            cmd_o.ev = dprr_pkg::EV_BAD;
          end else begin
            cmd_o.ev    = dprr_pkg::EV_GOOD;
            cmd_o.reply = reply_en_q;
          end
          phase_d = PH_IDLE;
          sum_d   = 8'd0;
          len_d   = 8'd0;
          hi_d    = 4'd0;
          hibad_d = 1'b0;
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      sum_q      <= 8'd0;
      len_q      <= 8'd0;
      hi_q       <= 4'd0;
      hibad_q    <= 1'b0;
      reply_en_q <= 1'b1;
    end else begin
      phase_q <= phase_d;
      sum_q   <= sum_d;
      len_q   <= len_d;
      hi_q    <= hi_d;
      hibad_q <= hibad_d;
      if (cfg_we_i) begin
        reply_en_q <= reply_empty_on_good_i;
      end
    end
  end

`include "debug_packet_receiver_responder_macros.svh"

  `DPRR_ASSERT_ALWAYS(a_len_in_range, len_q <= LEN_LIMIT, "payload length beyond capacity")

endmodule

// ===== src/dprr_cmdq.sv =====
module dprr_cmdq #(
  parameter int DEPTH = dprr_pkg::CMDQ_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dprr_pkg::cmd_t wdata_i,
  output logic           full_o,
  input  logic           pop_i,
  output dprr_pkg::cmd_t rdata_o,
  output logic           empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  dprr_pkg::cmd_t mem [DEPTH];

  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_FULL);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`include "debug_packet_receiver_responder_macros.svh"

  `DPRR_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CNT_FULL, "command queue count overrun")

endmodule

// ===== src/dprr_back.sv =====
module dprr_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dprr_pkg::cmd_t cmd_i,
  input  logic           cmd_empty_i,
  output logic           cmd_pop_o,
  output logic           empty_o,
  input  logic           pop_i,
  output logic [2:0]     event_code_o,
  output logic           tx_valid_o,
  output logic [7:0]     tx_byte_o,
  output logic           last_result_o
);

  localparam int RW = dprr_pkg::REM_W;
  localparam logic [RW-1:0] REM_FULL = RW'(dprr_pkg::REPLY_LEN);

  logic          vld_q, vld_d;
  logic [RW-1:0] rem_q, rem_d;
  logic [2:0]    ev_q, ev_d;
  logic          txv_q, txv_d;
  logic [7:0]    txb_q, txb_d;
  logic          last_q, last_d;
  logic          slot_free;

  // Output slot takes a new result when empty or being drained.
  assign slot_free = ~vld_q | pop_i;

  always_comb begin
    vld_d     = vld_q;
    rem_d     = rem_q;
    ev_d      = ev_q;
    txv_d     = txv_q;
    txb_d     = txb_q;
    last_d    = last_q;
    cmd_pop_o = 1'b0;
    if (slot_free) begin
      if (rem_q != '0) begin
        // Emit the next reply byte of "$#00".
        vld_d  = 1'b1;
        ev_d   = dprr_pkg::EV_NONE;
        txv_d  = 1'b1;
        last_d = (rem_q == RW'(1));
        rem_d  = rem_q - 1'b1;
        case (rem_q)
          RW'(4):  txb_d = dprr_pkg::CH_START;
          RW'(3):  txb_d = dprr_pkg::CH_CHECK;
          default: txb_d = dprr_pkg::CH_ZERO;
        endcase
      end else if (!cmd_empty_i) begin
        cmd_pop_o = 1'b1;
        vld_d     = 1'b1;
        ev_d      = cmd_i.ev;
        last_d    = ~cmd_i.reply;
        rem_d     = cmd_i.reply ? REM_FULL : '0;
        case (cmd_i.ev)
          dprr_pkg::EV_GOOD: begin
            txv_d = 1'b1;
            txb_d = dprr_pkg::CH_ACK;
          end
          dprr_pkg::EV_BAD: begin
            txv_d = 1'b1;
            txb_d = dprr_pkg::CH_NACK;
          end
          default: begin
            txv_d = 1'b0;
            txb_d = 8'd0;
          end
        endcase
      end else begin
        vld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      rem_q <= '0;
    end else begin
      vld_q <= vld_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_q   <= ev_d;
    txv_q  <= txv_d;
    txb_q  <= txb_d;
    last_q <= last_d;
  end

  assign empty_o       = ~vld_q;
  assign event_code_o  = ev_q;
  assign tx_valid_o    = txv_q;
  assign tx_byte_o     = txb_q;
  assign last_result_o = last_q;

`include "debug_packet_receiver_responder_macros.svh"

  `DPRR_ASSERT_ALWAYS(a_rem_needs_slot, (rem_q == '0) || vld_q, "reply bytes pending without result")
  `DPRR_ASSERT(a_rem_bound, rem_q <= REM_FULL, "reply counter overrun")
  `DPRR_ASSERT(a_silent_is_last, (vld_q && !txv_q) |-> last_q, "silent result not final")

endmodule

// ===== src/debug_packet_receiver_responder.sv =====
// Channel   Direction  Handshake              Payload
// --------  ---------  ---------------------  ----------------------------------------------
// request   in         push / full            rx_byte_i
// result    out        empty / pop            event_code_o, tx_valid_o, tx_byte_o,
//                                             last_result_o
// config    in         cfg_we_i (no wait)     reply_empty_on_good_i
//
// One request is taken per cycle while the command queue has room; framing, checksum and
// length tracking are done in the front part in the cycle of acceptance, and the first
// result of a request reaches the result ports through the command queue and the back part's
// output register. The back part delivers one result per cycle unless the result side stalls,
// so a good packet with the empty reply enabled gives five results, others give one.
// Silent requests ('$', payload bytes, '#', first digit) queue nothing. full rises when the
// CMDQ_DEPTH-entry command queue fills: behind a stalled result side, or when good packets
// come back to back, since "$#00" gives five results for four requests.
// Reset clears framing state, the queue and the output slot, and sets the reply enable.
module debug_packet_receiver_responder #(
  parameter int MAX_PACKET_BYTES = dprr_pkg::MAX_PACKET_BYTES_DEF,
  parameter int CMDQ_DEPTH       = dprr_pkg::CMDQ_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration
  input  logic       cfg_we_i,
  input  logic       reply_empty_on_good_i,
  // request side
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte_i,
  // result side
  output logic       empty,
  input  logic       pop,
  output logic [2:0] event_code_o,
  output logic       tx_valid_o,
  output logic [7:0] tx_byte_o,
  output logic       last_result_o
);

  logic           acc;
  logic           cmd_push;
  dprr_pkg::cmd_t cmd_wr;
  dprr_pkg::cmd_t cmd_rd;
  logic           cmd_empty;
  logic           cmd_pop;

  // Accept a request whenever the command queue can hold its outcome.
  assign acc = push & ~full;

  // Front: frame bytes, track sum and length, classify.
  dprr_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .reply_empty_on_good_i(reply_empty_on_good_i),
    .acc_i                (acc),
    .rx_byte_i            (rx_byte_i),
    .cmd_push_o           (cmd_push),
    .cmd_o                (cmd_wr)
  );

  // Decouple framing from result delivery.
  dprr_cmdq #(
    .DEPTH(CMDQ_DEPTH)
  ) u_cmdq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .wdata_i(cmd_wr),
    .full_o (full),
    .pop_i  (cmd_pop),
    .rdata_o(cmd_rd),
    .empty_o(cmd_empty)
  );

  // Back: expand each command into one or five results.
  dprr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_rd),
    .cmd_empty_i  (cmd_empty),
    .cmd_pop_o    (cmd_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .event_code_o (event_code_o),
    .tx_valid_o   (tx_valid_o),
    .tx_byte_o    (tx_byte_o),
    .last_result_o(last_result_o)
  );

endmodule

// ===== tb/tb_debug_packet_receiver_responder.sv =====
`timescale 1ns / 100ps

module tb_debug_packet_receiver_responder;

  // Payload room: the buffer also holds '$', '#' and the two checksum digits.
  localparam int BODY_MAX = dprr_pkg::MAX_PACKET_BYTES_DEF - 4;

  // One response item as the block presents it on the result side.
  typedef struct packed {
    logic [2:0] ev;
    logic       txv;
    logic [7:0] txb;
    logic       last;
  } resp_t;

  // Directed row: the request byte, plus a typed-in event code and result count
  // where the outcome is obvious without running the framing logic.
  typedef struct packed {
    logic [7:0] b;
    logic       typed;
    logic [2:0] ev;
    logic [2:0] n;
  } row_t;

  typedef enum logic [1:0] {FR_IDLE, FR_BODY, FR_CKH, FR_CKL} frame_phase_e;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic       reply_empty_on_good_i = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] rx_byte_i = 8'h00;
  logic       empty;
  logic       pop = 1'b0;
  logic [2:0] event_code_o;
  logic       tx_valid_o;
  logic [7:0] tx_byte_o;
  logic       last_result_o;

  debug_packet_receiver_responder uut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .reply_empty_on_good_i(reply_empty_on_good_i),
    .push                 (push),
    .full                 (full),
    .rx_byte_i            (rx_byte_i),
    .empty                (empty),
    .pop                  (pop),
    .event_code_o         (event_code_o),
    .tx_valid_o           (tx_valid_o),
    .tx_byte_o            (tx_byte_o),
    .last_result_o        (last_result_o)
  );

  // Framing state of the predictor, kept apart from the block.
  frame_phase_e frame_phase = FR_IDLE;
  logic [7:0]   body_sum = 8'h00;
  logic [7:0]   body_len = 8'h00;
  logic [3:0]   ck_hi = 4'h0;
  logic         ck_hi_bad = 1'b0;
  logic         reply_en = 1'b1;

  resp_t tx_expect_q[$];

  // Outcome of the latest accepted request, for the typed directed rows.
  int         step_n = 0;
  logic [2:0] step_ev = dprr_pkg::EV_NONE;

  int err_n = 0;
  int fed_n = 0;
  int checked_n = 0;
  int good_n = 0;
  int bad_n = 0;
  int ovf_n = 0;
  int burst_left = 0;
  int cyc_n = 0;
  int stall_mode = 0;

  // '$' 'a' '#' "61" is a good frame, "$#00" the empty one, then a frame with '$'
  // inside the body and a non-hex low digit, one with a non-hex high digit, and a
  // good frame with mixed-case digits.
  row_t dir_rows [0:28] = '{
    '{dprr_pkg::CH_ACK,   1'b1, dprr_pkg::EV_ACK,  3'd1},
    '{dprr_pkg::CH_NACK,  1'b1, dprr_pkg::EV_NACK, 3'd1},
    '{8'h00,              1'b1, dprr_pkg::EV_JUNK, 3'd1},
    '{8'hFF,              1'b1, dprr_pkg::EV_JUNK, 3'd1},
    '{dprr_pkg::CH_CHECK, 1'b1, dprr_pkg::EV_JUNK, 3'd1},
    '{dprr_pkg::CH_START, 1'b1, dprr_pkg::EV_NONE, 3'd0},
    '{8'h61,              1'b0, dprr_pkg::EV_NONE, 3'd0},
    '{dprr_pkg::CH_CHECK, 1'b1, dprr_pkg::EV_NONE, 3'd0},
    '{8'h36,              1'b0, dprr_pkg::EV_NONE, 3'd0},
    '{8'h31,              1'b1, dprr_pkg::EV_GOOD, 3'd5},
    '{dprr_pkg::CH_START, 1'b0, dprr_pkg::EV_NONE, 3'd0},
    '{dprr_pkg::CH_CHECK, 1'b0, dprr_pkg::EV_NONE, 3'd0},
    '{dprr_pkg::CH_ZERO,  1'b0, dprr_pkg::EV_NONE, 3'd0},
    '{dprr_pkg::CH_ZERO,  1'b1, dprr_pkg::EV_GOOD, 3'd5},
    '{dprr_pkg::CH_START, 1'b0, dprr_pkg::EV_NONE, 3'd0},
    '{8'hFF,              1'b0, dprr_pkg::EV_NONE, 3'd0},
    '{dprr_pkg::CH_START, 1'b0, dprr_pkg::EV_NONE, 3'd0},
    '{dprr_pkg::CH_CHECK, 1'b0, dprr_pkg::EV_NONE, 3'd0},
    '{8'h32,              1'b0, dprr_pkg::EV_NONE, 3'd0},
    '{8'h47,              1'b1, dprr_pkg::EV_BAD,  3'd1},
    '{dprr_pkg::CH_START, 1'b0, dprr_pkg::EV_NONE, 3'd0},
    '{dprr_pkg::CH_CHECK, 1'b0, dprr_pkg::EV_NONE, 3'd0},
    '{8'h7A,              1'b0, dprr_pkg::EV_NONE, 3'd0},
    '{dprr_pkg::CH_ZERO,  1'b1, dprr_pkg::EV_BAD,  3'd1},
    '{dprr_pkg::CH_START, 1'b0, dprr_pkg::EV_NONE, 3'd0},
    '{8'hCB,              1'b0, dprr_pkg::EV_NONE, 3'd0},
    '{dprr_pkg::CH_CHECK, 1'b0, dprr_pkg::EV_NONE, 3'd0},
    '{8'h63,              1'b0, dprr_pkg::EV_NONE, 3'd0},
    '{8'h42,              1'b0, dprr_pkg::EV_GOOD, 3'd5}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Bit 4 flags a valid hex digit, bits 3:0 carry its value.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
    if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h61 + 8'd10)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h41 + 8'd10)};
    return 5'h00;
  endfunction

  function automatic logic [7:0] nib_char(input logic [3:0] n, input logic upper);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (hex_nibble(c) != 5'h00);
    return c;
  endfunction

  task automatic queue_resp(input logic [2:0] ev, input logic txv, input logic [7:0] txb);
    resp_t r;
    r.ev = ev;
    r.txv = txv;
    r.txb = txv ? txb : 8'h00;
    r.last = 1'b0;
    if (step_n == 0) step_ev = ev;
    step_n++;
    tx_expect_q.push_back(r);
  endtask

  // Advance the framing predictor by one accepted byte and queue its responses.
  task automatic predict_responses(input logic [7:0] b);
    logic [4:0] hx;
    resp_t      r;
    step_n = 0;
    step_ev = dprr_pkg::EV_NONE;
    hx = hex_nibble(b);
    case (frame_phase)
      FR_IDLE: begin
        if (b == dprr_pkg::CH_START) begin
          frame_phase = FR_BODY;
          body_sum = 8'h00;
          body_len = 8'h00;
          ck_hi = 4'h0;
          ck_hi_bad = 1'b0;
        end else if (b == dprr_pkg::CH_ACK) begin
          queue_resp(dprr_pkg::EV_ACK, 1'b0, 8'h00);
        end else if (b == dprr_pkg::CH_NACK) begin
          queue_resp(dprr_pkg::EV_NACK, 1'b0, 8'h00);
        end else begin
          queue_resp(dprr_pkg::EV_JUNK, 1'b0, 8'h00);
        end
      end
      FR_BODY: begin
        if (b == dprr_pkg::CH_CHECK) begin
          frame_phase = FR_CKH;
        end else if (int'(body_len) >= BODY_MAX) begin
          // Drop the frame; whatever follows is read as bytes outside a frame.
          queue_resp(dprr_pkg::EV_OVERFLOW, 1'b0, 8'h00);
          ovf_n++;
          frame_phase = FR_IDLE;
          body_sum = 8'h00;
          body_len = 8'h00;
        end else begin
          body_sum = body_sum + b;
          body_len = body_len + 8'd1;
        end
      end
      FR_CKH: begin
        ck_hi = hx[4] ? hx[3:0] : 4'h0;
        ck_hi_bad = ~hx[4];
        frame_phase = FR_CKL;
      end
      default: begin
        if (!hx[4] || ck_hi_bad || {ck_hi, hx[3:0]} != body_sum) begin
          queue_resp(dprr_pkg::EV_BAD, 1'b1, dprr_pkg::CH_NACK);
          bad_n++;
        end else begin
          queue_resp(dprr_pkg::EV_GOOD, 1'b1, dprr_pkg::CH_ACK);
          good_n++;
          if (reply_en) begin
            queue_resp(dprr_pkg::EV_NONE, 1'b1, dprr_pkg::CH_START);
            queue_resp(dprr_pkg::EV_NONE, 1'b1, dprr_pkg::CH_CHECK);
            queue_resp(dprr_pkg::EV_NONE, 1'b1, dprr_pkg::CH_ZERO);
            queue_resp(dprr_pkg::EV_NONE, 1'b1, dprr_pkg::CH_ZERO);
          end
        end
        frame_phase = FR_IDLE;
        body_sum = 8'h00;
        body_len = 8'h00;
        ck_hi = 4'h0;
        ck_hi_bad = 1'b0;
      end
    endcase
    // Flag the final response of this request.
    if (step_n > 0) begin
      r = tx_expect_q.pop_back();
      r.last = 1'b1;
      tx_expect_q.push_back(r);
    end
  endtask

  // Sample both handshakes at the rising edge: predict on every accepted request,
  // check every accepted response against the oldest expectation.
  always @(posedge clk_i) begin
    resp_t e;
    if (!rst_ni) begin
      reply_en <= 1'b1;
    end else begin
      if (push && !full) predict_responses(rx_byte_i);
      if (cfg_we_i) reply_en <= reply_empty_on_good_i;
      if (pop && !empty) begin
        if (tx_expect_q.size() == 0) begin
          $error("unexpected response: event_code %0d tx_valid %0b tx_byte %02h last %0b",
                 event_code_o, tx_valid_o, tx_byte_o, last_result_o);
          err_n++;
        end else begin
          e = tx_expect_q.pop_front();
          checked_n++;
          if (event_code_o !== e.ev) begin
            $error("event_code: expected %0d, got %0d", e.ev, event_code_o);
            err_n++;
          end
          if (tx_valid_o !== e.txv) begin
            $error("tx_valid: expected %0b, got %0b", e.txv, tx_valid_o);
            err_n++;
          end
          if (tx_byte_o !== e.txb) begin
            $error("tx_byte: expected %02h, got %02h", e.txb, tx_byte_o);
            err_n++;
          end
          if (last_result_o !== e.last) begin
            $error("last_result: expected %0b, got %0b", e.last, last_result_o);
            err_n++;
          end
        end
      end
    end
  end

  // Receiver stalls: the stall mode is redrawn periodically among always ready, random stalls
  // and a repeating window that holds pop low for most of each period.
  always @(negedge clk_i) begin
    cyc_n++;
    if (cyc_n % 64 == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: pop <= 1'b1;
      1: pop <= ($urandom_range(0, 2) != 0);
      default: pop <= (cyc_n % 16) >= 10;
    endcase
  end

  // Drive one request at a falling edge and hold it until accepted. Requests go out
  // in bursts; between bursts push drops for a random gap, sometimes none at all.
  task automatic feed(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        push = 1'b0;
        rx_byte_i = 8'($urandom_range(0, 255));
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    push = 1'b1;
    rx_byte_i = b;
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
    fed_n++;
  endtask

  // Write the reply enable only once the block has gone quiet.
  task automatic set_reply(input logic v);
    push = 1'b0;
    burst_left = 0;
    while (tx_expect_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    cfg_we_i = 1'b1;
    reply_empty_on_good_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Send one frame. A negative length picks a random one, mostly short, now and then
  // near or past capacity. Unless clean, some frames are cut short or get a wrong
  // or non-hex checksum digit.
  task automatic send_packet(input int force_len, input logic clean);
    int         len;
    int         mode;
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] hi_c;
    logic [7:0] lo_c;
    if (force_len >= 0) len = force_len;
    else if ($urandom_range(0, 39) == 0) len = $urandom_range(BODY_MAX - 6, BODY_MAX + 6);
    else len = $urandom_range(0, 12);
    sum = 8'h00;
    feed(dprr_pkg::CH_START);
    for (int i = 0; i < len; i++) begin
      do b = 8'($urandom_range(0, 255)); while (b == dprr_pkg::CH_CHECK);
      sum = sum + b;
      feed(b);
    end
    if (!clean && $urandom_range(0, 19) == 0) return;
    feed(dprr_pkg::CH_CHECK);
    hi_c = nib_char(sum[7:4], 1'($urandom_range(0, 1)));
    lo_c = nib_char(sum[3:0], 1'($urandom_range(0, 1)));
    mode = clean ? 9 : $urandom_range(0, 9);
    case (mode)
      0: hi_c = nib_char(sum[7:4] ^ 4'($urandom_range(1, 15)), 1'($urandom_range(0, 1)));
      1: lo_c = nib_char(sum[3:0] ^ 4'($urandom_range(1, 15)), 1'($urandom_range(0, 1)));
      2: hi_c = non_hex_byte();
      3: lo_c = non_hex_byte();
      default: ;
    endcase
    feed(hi_c);
    feed(lo_c);
  endtask

  // Mostly well-formed frames, with stray acks, nacks and junk in between.
  task automatic run_random(input int n_items);
    int target;
    int r;
    target = fed_n + n_items;
    while (fed_n < target) begin
      repeat ($urandom_range(0, 2)) begin
        r = $urandom_range(0, 3);
        if (r == 0) feed(dprr_pkg::CH_ACK);
        else if (r == 1) feed(dprr_pkg::CH_NACK);
        else feed(8'($urandom_range(0, 255)));
      end
      send_packet(-1, 1'b0);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed table, reply enable at its reset value.
    foreach (dir_rows[i]) begin
      feed(dir_rows[i].b);
      if (dir_rows[i].typed && (step_n != int'(dir_rows[i].n) || step_ev != dir_rows[i].ev)) begin
        $error("event_code: row %0d expected %0d x%0d, predicted %0d x%0d",
               i, dir_rows[i].ev, dir_rows[i].n, step_ev, step_n);
        err_n++;
      end
    end

    set_reply(1'b0);
    run_random(15);

    // Fill the body exactly to capacity, then go one byte past it.
    set_reply(1'b1);
    send_packet(BODY_MAX, 1'b1);
    send_packet(BODY_MAX + 1, 1'b1);
    run_random(15);

    set_reply(1'b0);
    run_random(15);
    set_reply(1'b1);
    run_random(15);

    // Drain: wait for every expected response, then hold a little longer to catch extras.
    push = 1'b0;
    while (tx_expect_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (tx_expect_q.size() != 0) begin
      $error("%0d responses never arrived", tx_expect_q.size());
      err_n++;
    end

    $display("run covered %0d requests: %0d good, %0d bad-checksum, %0d overflow frames",
             fed_n, good_n, bad_n, ovf_n);
    $display("%0d responses checked with the empty reply both on and off", checked_n);
    if (err_n == 0) begin
      $display("tb_debug_packet_receiver_responder: done, clean");
    end else begin
      $display("tb_debug_packet_receiver_responder: done, errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("tb_debug_packet_receiver_responder: done, errors");
    $finish;
  end

endmodule
